/* sv/rmv_pkg.sv */
// ----------------------------------------------------------------------------
// rmv_pkg
// Shared constants and types for the running mean and variance block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmv_pkg;

  localparam int COUNT_BITS_DEF     = 32;
  localparam int MEAN_FRAC_BITS_DEF = 16;
  localparam int SAMPLE_W           = 16;
  localparam int M2_W               = 63;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_MEAN = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_ACC  = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mean_en;
    logic mul_en;
    logic acc_en;
  } cmd_t;

endpackage

`default_nettype wire

/* sv/rmv_ctrl.sv */
// ----------------------------------------------------------------------------
// rmv_ctrl
// Sequencer: takes a request, steps the divider, the mean update, the
// multiply and the accumulate, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rmv_ctrl #(
  parameter int MFB = rmv_pkg::MEAN_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output rmv_pkg::cmd_t cmd
);

  localparam int DW = 9 + MFB;
  localparam int CW = $clog2(DW);
  localparam logic [CW-1:0] LAST = CW'(DW - 1);

  rmv_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      rmv_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = rmv_pkg::ST_DIV;
        end
      end
      rmv_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = rmv_pkg::ST_MEAN;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      rmv_pkg::ST_MEAN: begin
        cmd.mean_en = 1'b1;
        state_nxt   = rmv_pkg::ST_MUL;
      end
      rmv_pkg::ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = rmv_pkg::ST_ACC;
      end
      rmv_pkg::ST_ACC: begin
        if (out_free) begin
          cmd.acc_en = 1'b1;
          state_nxt  = rmv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rmv_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.acc_en || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmv_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != rmv_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* sv/rmv_datapath.sv */
// ----------------------------------------------------------------------------
// rmv_datapath
// Statistics registers, radix-2 restoring divider, mean update, deviation
// product and saturating M2 accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module rmv_datapath #(
  parameter int CB  = rmv_pkg::COUNT_BITS_DEF,
  parameter int MFB = rmv_pkg::MEAN_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rmv_pkg::cmd_t                     cmd,
  input  logic signed [rmv_pkg::SAMPLE_W-1:0] in_sample,
  output logic signed [8+MFB-1:0]           out_running_mean,
  output logic [rmv_pkg::M2_W-1:0]          out_squared_dev_sum,
  output logic [CB-1:0]                     out_sample_total,
  output logic [CB-1:0]                     out_positive_total,
  output logic [CB-1:0]                     out_zero_total
);

  localparam int MW  = 8 + MFB;
  localparam int DW  = MW + 1;
  localparam int S   = MFB - 8;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW - S;
  localparam int M2W = rmv_pkg::M2_W;
  localparam int EW  = (SW > M2W) ? SW : M2W + 1;

  // statistics
  logic signed [MW-1:0] mean_r;
  logic [M2W-1:0]       m2_r, m2_nxt;
  logic [CB-1:0]        count_r, pos_r, zero_r;

  // per-request scratch
  logic signed [MW-1:0] xs_r;
  logic                 xpos_r, xzero_r;
  logic                 d1neg_r;
  logic [DW-1:0]        d1mag_r;
  logic [CB-1:0]        div_r;
  logic [CB-1:0]        rem_r, rem_nxt;
  logic [DW-1:0]        quo_r;
  logic signed [MW-1:0] nmean_r;
  logic [DW-1:0]        d2mag_r;
  logic [PW-1:0]        prod_r;

  // load
  logic signed [MW-1:0] xs_w;
  logic signed [DW-1:0] d1_w;
  logic [DW-1:0]        d1mag_w;
  logic [CB-1:0]        n_w;

  assign xs_w    = MW'(in_sample) <<< S;
  assign d1_w    = DW'(xs_w) - DW'(mean_r);
  assign d1mag_w = d1_w[DW-1] ? DW'(-d1_w) : DW'(d1_w);
  assign n_w     = (count_r == '1) ? count_r : count_r + CB'(1);

  // divide step
  logic [CB:0] trial_w, diff_w;
  logic        ge_w;

  assign trial_w = {rem_r, quo_r[DW-1]};
  assign diff_w  = trial_w - {1'b0, div_r};
  assign ge_w    = (trial_w >= {1'b0, div_r});
  assign rem_nxt = ge_w ? diff_w[CB-1:0] : trial_w[CB-1:0];

  // mean update
  logic signed [DW:0]   q_w, nm_sum_w;
  logic signed [MW-1:0] nmean_w;
  logic signed [DW-1:0] d2_w;
  logic [DW-1:0]        d2mag_w;

  assign q_w      = d1neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign nm_sum_w = (DW+1)'(mean_r) + q_w;
  assign nmean_w  = nm_sum_w[MW-1:0];
  assign d2_w     = DW'(xs_r) - DW'(nmean_w);
  assign d2mag_w  = d2_w[DW-1] ? DW'(-d2_w) : DW'(d2_w);

  // accumulate
  logic [EW-1:0]  add_ext_w;
  logic [M2W-1:0] add_w;
  logic [M2W:0]   sum_w;

  assign add_ext_w = EW'(prod_r >> S);
  assign add_w     = (|add_ext_w[EW-1:M2W]) ? '1 : add_ext_w[M2W-1:0];
  assign sum_w     = {1'b0, m2_r} + {1'b0, add_w};
  assign m2_nxt    = sum_w[M2W] ? '1 : sum_w[M2W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xs_r    <= xs_w;
      xpos_r  <= (in_sample > 0);
      xzero_r <= (in_sample == 0);
      d1neg_r <= d1_w[DW-1];
      d1mag_r <= d1mag_w;
      quo_r   <= d1mag_w;
      rem_r   <= '0;
      div_r   <= n_w;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DW-2:0], ge_w};
    end
    if (cmd.mean_en) begin
      nmean_r <= nmean_w;
      d2mag_r <= d2mag_w;
    end
    if (cmd.mul_en) begin
      prod_r <= d1mag_r * d2mag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r  <= '0;
      m2_r    <= '0;
      count_r <= '0;
      pos_r   <= '0;
      zero_r  <= '0;
    end else if (cmd.acc_en) begin
      mean_r  <= nmean_r;
      m2_r    <= m2_nxt;
      count_r <= div_r;
      if (xpos_r && (pos_r != '1)) begin
        pos_r <= pos_r + CB'(1);
      end
      if (xzero_r && (zero_r != '1)) begin
        zero_r <= zero_r + CB'(1);
      end
    end
  end

  assign out_running_mean    = mean_r;
  assign out_squared_dev_sum = m2_r;
  assign out_sample_total    = count_r;
  assign out_positive_total  = pos_r;
  assign out_zero_total      = zero_r;

endmodule

`default_nettype wire

/* sv/running_mean_variance.sv */
// ----------------------------------------------------------------------------
// running_mean_variance
// Welford running mean and variance over signed Q8.8 samples.
//
// Input channel in_*: one sample per request. Result channel out_*: the
// updated mean, M2, sample count and positive / zero counts, one result per
// request. Both channels use valid / stall.
// The radix-2 divider takes one quotient bit a cycle over MEAN_FRAC_BITS+9
// bits; the mean update, the multiply and the accumulate follow in turn.
// The block takes no new request until it is through with the current one.
// A new request is taken while the previous result still waits; the
// accumulate step holds until that result is taken, so a stalled receiver
// backs up into in_stall.
// Reset clears all statistics and the result valid flag; the block comes
// out of reset idle, ready to take a request.
// ----------------------------------------------------------------------------
`default_nettype none

module running_mean_variance #(
  parameter int COUNT_BITS     = rmv_pkg::COUNT_BITS_DEF,
  parameter int MEAN_FRAC_BITS = rmv_pkg::MEAN_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rmv_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [8+MEAN_FRAC_BITS-1:0]  out_running_mean,
  output logic [rmv_pkg::M2_W-1:0]            out_squared_dev_sum,
  output logic [COUNT_BITS-1:0]               out_sample_total,
  output logic [COUNT_BITS-1:0]               out_positive_total,
  output logic [COUNT_BITS-1:0]               out_zero_total
);

  rmv_pkg::cmd_t cmd;

  rmv_ctrl #(
    .MFB (MEAN_FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  rmv_datapath #(
    .CB  (COUNT_BITS),
    .MFB (MEAN_FRAC_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_sample           (in_sample),
    .out_running_mean    (out_running_mean),
    .out_squared_dev_sum (out_squared_dev_sum),
    .out_sample_total    (out_sample_total),
    .out_positive_total  (out_positive_total),
    .out_zero_total      (out_zero_total)
  );

endmodule

`default_nettype wire

/* sv/rmv_checker.sv */
// ----------------------------------------------------------------------------
// rmv_checker
// Port-level checks for the running mean and variance block, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rmv_checker #(
  parameter int CB  = rmv_pkg::COUNT_BITS_DEF,
  parameter int MFB = rmv_pkg::MEAN_FRAC_BITS_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [8+MFB-1:0]             out_running_mean,
  input logic [rmv_pkg::M2_W-1:0]            out_squared_dev_sum,
  input logic [CB-1:0]                       out_sample_total,
  input logic [CB-1:0]                       out_positive_total,
  input logic [CB-1:0]                       out_zero_total
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one still in work");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample_total != '0) &&
                  (out_positive_total <= out_sample_total) &&
                  (out_zero_total <= out_sample_total))
    else $error("result counts inconsistent");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_running_mean) &&
                               $stable(out_squared_dev_sum) &&
                               $stable(out_sample_total))
    else $error("stalled result changed");

endmodule

bind running_mean_variance rmv_checker #(
  .CB  (COUNT_BITS),
  .MFB (MEAN_FRAC_BITS)
) u_rmv_checker (.*);

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for running_mean_variance. A short table of directed
// samples (extremes, sign changes, zeros, repeated values) runs first, then
// about fifteen hundred random samples built as uniform values, clusters,
// runs of a constant, extremes and small values. An internal Welford model
// predicts each result but those a table row gives; each accepted result
// is compared field by field in order. Both channels idle at random, and
// the receiver holds off once long enough to back the block up into in_stall.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEAN_W   = 8 + rmv_pkg::MEAN_FRAC_BITS_DEF;
  localparam int CNT_W    = rmv_pkg::COUNT_BITS_DEF;
  localparam int FRAC_SH  = rmv_pkg::MEAN_FRAC_BITS_DEF - 8;
  localparam int ITEMS    = 1550;
  localparam int N_DIR    = 22;
  localparam logic [63:0] M2_MAX = {1'b0, {63{1'b1}}};

  typedef struct packed {
    logic signed [MEAN_W-1:0]   mean;
    logic [rmv_pkg::M2_W-1:0]   m2;
    logic [CNT_W-1:0]           total;
    logic [CNT_W-1:0]           positive;
    logic [CNT_W-1:0]           zeros;
  } stats_t;

  typedef struct packed {
    logic signed [rmv_pkg::SAMPLE_W-1:0] sample;
    logic                                typed;
    stats_t                              want;
  } dir_row_t;

  logic                                clk;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic signed [rmv_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [MEAN_W-1:0]            out_running_mean;
  logic [rmv_pkg::M2_W-1:0]            out_squared_dev_sum;
  logic [CNT_W-1:0]                    out_sample_total;
  logic [CNT_W-1:0]                    out_positive_total;
  logic [CNT_W-1:0]                    out_zero_total;

  logic signed [MEAN_W-1:0]   mean_acc = '0;
  logic [rmv_pkg::M2_W-1:0]   m2_acc = '0;
  logic [CNT_W-1:0]           count_acc = '0;
  logic [CNT_W-1:0]           positive_acc = '0;
  logic [CNT_W-1:0]           zero_acc = '0;

  stats_t expected_stats[$];
  int     accepted_count = 0;
  int     errors = 0;
  int     calm_items = 0;

  dir_row_t dir_rows [0:N_DIR-1] = '{
    '{16'sh7fff, 1'b1, '{24'sh7fff00, 63'd0, 32'd1, 32'd1, 32'd0}},
    '{16'sh8000, 1'b1, '{-24'sd128, 63'd549739036800, 32'd2, 32'd1, 32'd0}},
    '{16'sh0000, 1'b1, '{-24'sd86, 63'd549739036843, 32'd3, 32'd1, 32'd1}},
    '{16'shffff, 1'b0, '0},
    '{16'sh0001, 1'b0, '0},
    '{16'sh0100, 1'b0, '0},
    '{16'shff00, 1'b0, '0},
    '{16'sh5555, 1'b0, '0},
    '{16'shaaaa, 1'b0, '0},
    '{16'sh7fff, 1'b0, '0},
    '{16'sh7fff, 1'b0, '0},
    '{16'sh7fff, 1'b0, '0},
    '{16'sh8000, 1'b0, '0},
    '{16'sh8000, 1'b0, '0},
    '{16'sh8000, 1'b0, '0},
    '{16'sh0000, 1'b0, '0},
    '{16'sh0000, 1'b0, '0},
    '{16'sh0080, 1'b0, '0},
    '{16'shff80, 1'b0, '0},
    '{16'sh4000, 1'b0, '0},
    '{16'shc000, 1'b0, '0},
    '{16'sh8001, 1'b0, '0}
  };

  running_mean_variance dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_running_mean    (out_running_mean),
    .out_squared_dev_sum (out_squared_dev_sum),
    .out_sample_total    (out_sample_total),
    .out_positive_total  (out_positive_total),
    .out_zero_total      (out_zero_total)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic stats_t welford_update(input logic signed [rmv_pkg::SAMPLE_W-1:0] x);
    longint      xs, old_m, new_m, d1, d2, q;
    logic [63:0] n, mag1, mag2, qmag, prod, add, room;
    stats_t      r;
    xs    = longint'(x) * (longint'(1) << FRAC_SH);
    old_m = longint'(mean_acc);
    n     = (&count_acc) ? {32'd0, count_acc} : {32'd0, count_acc} + 64'd1;
    d1    = xs - old_m;
    mag1  = (d1 < 0) ? -d1 : d1;
    qmag  = mag1 / n;
    q     = (d1 < 0) ? -longint'(qmag) : longint'(qmag);
    new_m = old_m + q;
    d2    = xs - new_m;
    mag2  = (d2 < 0) ? -d2 : d2;
    prod  = mag1 * mag2;
    add   = prod >> FRAC_SH;
    room  = M2_MAX - {1'b0, m2_acc};
    if (add > room) begin
      m2_acc = '1;
    end else begin
      m2_acc = m2_acc + add[rmv_pkg::M2_W-1:0];
    end
    mean_acc  = new_m[MEAN_W-1:0];
    count_acc = n[CNT_W-1:0];
    if (x > 0) begin
      positive_acc = (&positive_acc) ? positive_acc : positive_acc + 1'b1;
    end else if (x == 0) begin
      zero_acc = (&zero_acc) ? zero_acc : zero_acc + 1'b1;
    end
    r.mean     = mean_acc;
    r.m2       = m2_acc;
    r.total    = count_acc;
    r.positive = positive_acc;
    r.zeros    = zero_acc;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_items > 0) begin
      calm_items--;
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 96) return $urandom_range(5, 40);
    return $urandom_range(60, 200);
  endfunction

  task automatic send_sample(input logic signed [rmv_pkg::SAMPLE_W-1:0] v,
                             input logic typed, input stats_t want);
    int     gap;
    stats_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= v;
    do @(posedge clk); while (in_stall);
    predicted = welford_update(v);
    expected_stats.push_back(typed ? want : predicted);
    accepted_count++;
  endtask

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    stats_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_stats.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = expected_stats.pop_front();
        check_field("running_mean", longint'(want.mean), longint'(out_running_mean));
        check_field("squared_dev_sum", longint'(want.m2), longint'(out_squared_dev_sum));
        check_field("sample_total", longint'(want.total), longint'(out_sample_total));
        check_field("positive_total", longint'(want.positive),
                    longint'(out_positive_total));
        check_field("zero_total", longint'(want.zeros), longint'(out_zero_total));
      end
    end
  end

  initial begin : receiver
    int r, len;
    bit held;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && accepted_count >= 300) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 20) begin
          out_stall <= 1'b0;
          len = $urandom_range(50, 200);
        end else if (r < 60) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 15);
        end else if (r < 92) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 4);
        end else begin
          out_stall <= 1'b1;
          len = $urandom_range(20, 90);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int r, len, base, span, val;
    bit paused;
    logic signed [rmv_pkg::SAMPLE_W-1:0] v;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      send_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].want);
    end

    while (accepted_count < ITEMS) begin
      if (!paused && accepted_count >= 800) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_stats.size() != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 3) calm_items = $urandom_range(20, 60);
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send_sample(16'($urandom_range(0, 65535)), 1'b0, '0);
      end else if (r < 65) begin
        base = int'($urandom_range(0, 65535)) - 32768;
        span = 1 << $urandom_range(0, 10);
        len  = $urandom_range(5, 30);
        repeat (len) begin
          val = base + int'($urandom_range(0, 2 * span)) - span;
          if (val > 32767) val = 32767;
          if (val < -32768) val = -32768;
          send_sample(16'(val), 1'b0, '0);
        end
      end else if (r < 75) begin
        len = $urandom_range(3, 10);
        repeat (len) begin
          case ($urandom_range(0, 5))
            0:       v = 16'sh7fff;
            1:       v = 16'sh8000;
            2:       v = 16'sh0000;
            3:       v = 16'sh0001;
            4:       v = 16'shffff;
            default: v = 16'sh8001;
          endcase
          send_sample(v, 1'b0, '0);
        end
      end else if (r < 90) begin
        len = $urandom_range(5, 25);
        repeat (len) send_sample(16'(int'($urandom_range(0, 8)) - 4), 1'b0, '0);
      end else begin
        v   = 16'($urandom_range(0, 65535));
        len = $urandom_range(5, 40);
        repeat (len) send_sample(v, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (expected_stats.size() != 0);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* filelist.f */
sv/rmv_pkg.sv
sv/rmv_ctrl.sv
sv/rmv_datapath.sv
sv/running_mean_variance.sv
sv/rmv_checker.sv
dv/tb_top.sv
